@@ src/ren_pkg.sv @@
//------------------------------------------------------------------------------
// ren_pkg: ring election node shared types and constants
// Operation and message codes, register indexes, queue entry type.
//------------------------------------------------------------------------------
`default_nettype none
package ren_pkg;
    localparam int ID_BITS_DEF = 16;

    typedef enum logic [3:0] {
        OP_TICK = 4'd0, OP_HEARTBEAT = 4'd1, OP_DEATH = 4'd2, OP_ELECTION = 4'd3,
        OP_VICTORY = 4'd4, OP_COUNT = 4'd5, OP_CHANGE_NEXT = 4'd6,
        OP_PING = 4'd7, OP_START = 4'd8
    } op_t;

    localparam logic [2:0] MK_HEARTBEAT = 3'd0;
    localparam logic [2:0] MK_DEATH     = 3'd1;
    localparam logic [2:0] MK_ELECTION  = 3'd2;
    localparam logic [2:0] MK_VICTORY   = 3'd3;
    localparam logic [2:0] MK_COUNT     = 3'd4;
    localparam logic [2:0] MK_PING_REP  = 3'd5;
    localparam logic [2:0] MK_COUNT_END = 3'd6;

    localparam logic [2:0] REG_SELF_ID    = 3'd0;
    localparam logic [2:0] REG_HB_GAP     = 3'd1;
    localparam logic [2:0] REG_HB_TIMEOUT = 3'd2;
    localparam logic [2:0] REG_DEATH_GAP  = 3'd3;
    localparam logic [2:0] REG_RELAY_TO   = 3'd4;
    localparam logic [2:0] REG_COUNT_GAP  = 3'd5;

    typedef struct packed {
        logic [3:0]  operation;
        logic [15:0] sender_id;
        logic [31:0] msg_time;
        logic [15:0] arg_a;
        logic [15:0] arg_b;
    } item_t;

    typedef struct packed {
        logic [2:0]  msg_kind;
        logic [15:0] dest_id;
        logic [31:0] out_time;
        logic [15:0] out_a;
        logic [15:0] out_b;
        logic        last;
    } msg_t;
endpackage
`default_nettype wire

@@ src/ren_front.sv @@
//------------------------------------------------------------------------------
// ren_front: input stage
// Registers accepted items into a two-entry queue towards the node engine.
//------------------------------------------------------------------------------
`default_nettype none
module ren_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire ren_pkg::item_t in_item,
    output logic               q_valid,
    input  wire logic          q_ready,
    output ren_pkg::item_t     q_item
);
    import ren_pkg::*;

    item_t       mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !in_ready)
        else $error("queue overflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");
endmodule
`default_nettype wire

@@ src/ren_engine.sv @@
//------------------------------------------------------------------------------
// ren_engine: node state and message generation
// Takes one queued item, updates state and emits up to three messages in turn.
//------------------------------------------------------------------------------
`default_nettype none
module ren_engine
#(
    parameter int ID_BITS = ren_pkg::ID_BITS_DEF
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cfg_we,
    input  wire logic [2:0]     cfg_index,
    input  wire logic [31:0]    cfg_data,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire ren_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ren_pkg::msg_t       out_msg
);
    import ren_pkg::*;

    localparam logic [15:0] ID_MASK = 16'((33'd1 << ID_BITS) - 33'd1);

    logic [15:0] self_id_reg;
    logic [31:0] hb_gap_reg, hb_to_reg, death_gap_reg, relay_to_reg, count_gap_reg;
    logic [31:0] local_time_reg, hb_rx_reg, hb_tx_reg, death_t_reg, count_t_reg;
    logic [15:0] next_reg, coord_reg, hb_sender_reg, ring_size_reg;
    logic        head_reg, counting_reg;

    // pending tick messages: heartbeat, death, count
    logic [2:0]  pend_reg;
    msg_t        pm_reg [3];
    logic        out_valid_reg;
    msg_t        out_reg;

    logic        busy, load, take;
    logic [31:0] lt1;
    logic [15:0] a_m, b_m, snd_m;
    logic        hb_fire, dead, death_fire, cnt_fire;
    logic [15:0] cnt_dest;

    assign busy      = (pend_reg != 3'd0);
    assign out_valid = out_valid_reg;
    assign out_msg   = out_reg;
    assign take      = !out_valid_reg || out_ready;
    assign q_ready   = !busy && take;
    assign load      = q_valid && q_ready;

    assign lt1   = local_time_reg + 32'd1;
    assign a_m   = q_item.arg_a & ID_MASK;
    assign b_m   = q_item.arg_b & ID_MASK;
    assign snd_m = q_item.sender_id & ID_MASK;
    assign hb_fire    = (lt1 - hb_tx_reg) > hb_gap_reg;
    assign dead       = ((lt1 - hb_rx_reg) > hb_to_reg) && ((lt1 - death_t_reg) > death_gap_reg);
    assign death_fire = dead && (next_reg != hb_sender_reg);
    assign cnt_fire   = (self_id_reg == coord_reg) && !counting_reg
                        && ((lt1 - count_t_reg) > count_gap_reg);
    // count message goes to the new next node when the ring closes on itself
    assign cnt_dest   = (dead && !death_fire) ? self_id_reg : next_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg <= 16'd1; hb_gap_reg <= 32'd100; hb_to_reg <= 32'd500;
            death_gap_reg <= 32'd200; relay_to_reg <= 32'd1000; count_gap_reg <= 32'd1000;
            local_time_reg <= '0; hb_rx_reg <= '0; hb_tx_reg <= '0;
            death_t_reg <= '0; count_t_reg <= '0;
            next_reg <= '0; coord_reg <= '0; hb_sender_reg <= '0; ring_size_reg <= '0;
            head_reg <= 1'b0; counting_reg <= 1'b0;
            pend_reg <= 3'd0; out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SELF_ID:    self_id_reg <= cfg_data[15:0] & ID_MASK;
                    REG_HB_GAP:     hb_gap_reg <= cfg_data;
                    REG_HB_TIMEOUT: hb_to_reg <= cfg_data;
                    REG_DEATH_GAP:  death_gap_reg <= cfg_data;
                    REG_RELAY_TO:   relay_to_reg <= cfg_data;
                    REG_COUNT_GAP:  count_gap_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (busy && take)
            begin
                // drain pending tick messages lowest first
                out_valid_reg <= 1'b1;
                if (pend_reg[0])
                begin
                    out_reg <= pm_reg[0];
                    out_reg.last <= (pend_reg[2:1] == 2'b00);
                    pend_reg[0] <= 1'b0;
                end
                else if (pend_reg[1])
                begin
                    out_reg <= pm_reg[1];
                    out_reg.last <= !pend_reg[2];
                    pend_reg[1] <= 1'b0;
                end
                else
                begin
                    out_reg <= pm_reg[2];
                    out_reg.last <= 1'b1;
                    pend_reg[2] <= 1'b0;
                end
            end
            if (load)
            begin
                out_reg.last <= 1'b1;
                out_reg.out_time <= local_time_reg;
                out_reg.dest_id <= next_reg;
                case (q_item.operation)
                    OP_TICK:
                    begin
                        local_time_reg <= lt1;
                        pm_reg[0] <= '{MK_HEARTBEAT, next_reg, lt1, self_id_reg, 16'd0, 1'b0};
                        pm_reg[1] <= '{MK_DEATH, next_reg, lt1, hb_sender_reg, self_id_reg, 1'b0};
                        pm_reg[2] <= '{MK_COUNT, cnt_dest, lt1, self_id_reg, 16'd0, 1'b0};
                        pend_reg <= {cnt_fire, death_fire, hb_fire};
                        if (hb_fire) hb_tx_reg <= lt1;
                        if (death_fire) death_t_reg <= lt1;
                        if (dead && !death_fire)
                        begin
                            head_reg <= 1'b1;
                            next_reg <= self_id_reg;
                        end
                        if (cnt_fire)
                        begin
                            count_t_reg <= lt1;
                            counting_reg <= 1'b1;
                        end
                    end
                    OP_HEARTBEAT:
                    begin
                        hb_rx_reg <= q_item.msg_time;
                        hb_sender_reg <= snd_m;
                    end
                    OP_DEATH:
                    begin
                        if (next_reg == a_m)
                        begin
                            next_reg <= b_m;
                            out_reg.dest_id <= b_m;
                            out_reg.msg_kind <= MK_ELECTION;
                            out_reg.out_a <= self_id_reg;
                            out_reg.out_b <= self_id_reg;
                            out_valid_reg <= (next_reg == coord_reg);
                        end
                        else
                        begin
                            out_reg.msg_kind <= MK_DEATH;
                            out_reg.out_time <= q_item.msg_time;
                            out_reg.out_a <= a_m;
                            out_reg.out_b <= b_m;
                            out_valid_reg <= (self_id_reg != b_m)
                                && ((local_time_reg - q_item.msg_time) <= relay_to_reg);
                        end
                    end
                    OP_ELECTION:
                    begin
                        out_valid_reg <= 1'b1;
                        if (a_m == self_id_reg)
                        begin
                            counting_reg <= 1'b0;
                            ring_size_reg <= '0;
                            coord_reg <= b_m;
                            out_reg.msg_kind <= MK_VICTORY;
                            out_reg.out_a <= self_id_reg;
                            out_reg.out_b <= b_m;
                        end
                        else
                        begin
                            out_reg.msg_kind <= MK_ELECTION;
                            out_reg.out_a <= a_m;
                            out_reg.out_b <= (b_m > self_id_reg) ? b_m : self_id_reg;
                        end
                    end
                    OP_VICTORY:
                    begin
                        out_reg.msg_kind <= MK_VICTORY;
                        out_reg.out_a <= a_m;
                        out_reg.out_b <= b_m;
                        out_valid_reg <= (a_m != self_id_reg);
                        if (a_m != self_id_reg)
                        begin
                            counting_reg <= 1'b0;
                            ring_size_reg <= '0;
                            coord_reg <= b_m;
                        end
                    end
                    OP_COUNT:
                    begin
                        out_reg.out_a <= a_m;
                        if (self_id_reg == coord_reg)
                        begin
                            out_reg.msg_kind <= MK_COUNT_END;
                            out_reg.out_b <= q_item.arg_b;
                            out_valid_reg <= (a_m == coord_reg);
                            if (a_m == coord_reg)
                            begin
                                counting_reg <= 1'b0;
                                ring_size_reg <= q_item.arg_b;
                            end
                        end
                        else
                        begin
                            out_reg.msg_kind <= MK_COUNT;
                            out_reg.out_b <= q_item.arg_b + 16'd1;
                            out_valid_reg <= 1'b1;
                        end
                    end
                    OP_CHANGE_NEXT: next_reg <= a_m;
                    OP_PING:
                    begin
                        out_reg.msg_kind <= MK_PING_REP;
                        out_reg.dest_id <= snd_m;
                        out_reg.out_a <= self_id_reg;
                        out_reg.out_b <= 16'd0;
                        out_valid_reg <= 1'b1;
                    end
                    OP_START:
                    begin
                        out_reg.msg_kind <= MK_ELECTION;
                        out_reg.out_a <= self_id_reg;
                        out_reg.out_b <= self_id_reg;
                        out_valid_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !q_ready)
        else $error("item taken while tick messages pending");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_msg))
        else $error("result dropped while stalled");
    a_pend_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        busy && take |=> $countones(pend_reg) == $countones($past(pend_reg)) - 1)
        else $error("pending message lost");
endmodule
`default_nettype wire

@@ src/ring_election_node.sv @@
//------------------------------------------------------------------------------
// ring_election_node: one node of a ring leader election
// Input queue in front of the node engine.
//------------------------------------------------------------------------------
// channel  dir  tdata (low bit up)                             tuser
// s_axis   in   sender_id, msg_time, arg_a, arg_b (80 bits)   operation (4)
// m_axis   out  dest_id, out_time, out_a, out_b (80 bits)     msg_kind (3); tlast=last
// cfg      in   cfg_we, cfg_index, cfg_data (32)
// An item is accepted each cycle while the queue has room; a tick yielding
// messages holds the engine while it first classifies the tick, then sends one
// message per cycle, unless the output stalls, through the single output register.
// Other items, and ticks with no message, do not hold the engine. Reset clears
// the queue pointers and count, configuration and node state at once; a stalled
// output holds the engine, the queue absorbs two further items.
//------------------------------------------------------------------------------
`default_nettype none
module ring_election_node
#(
    parameter int ID_BITS = ren_pkg::ID_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,  // sender_id, msg_time, arg_a, arg_b
    input  wire logic [3:0]  s_axis_tuser,  // operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // dest_id, out_time, out_a, out_b
    output logic [2:0]       m_axis_tuser,  // msg_kind
    output logic             m_axis_tlast
);
    import ren_pkg::*;

    item_t in_item, q_item;
    msg_t  out_msg;
    logic  q_valid, q_ready;

    assign in_item = '{s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
                       s_axis_tdata[63:48], s_axis_tdata[79:64]};

    ren_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    ren_engine #(.ID_BITS(ID_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_msg(out_msg)
    );

    assign m_axis_tdata = {out_msg.out_b, out_msg.out_a, out_msg.out_time, out_msg.dest_id};
    assign m_axis_tuser = out_msg.msg_kind;
    assign m_axis_tlast = out_msg.last;
endmodule
`default_nettype wire

@@ bench/tb_ring_election_node.sv @@
//------------------------------------------------------------------------------
// tb_ring_election_node: stream-level check of one ring election node
// Drives ticks and ring messages through the input stream, predicts the
// outgoing messages in the bench and compares every output transfer in order.
//------------------------------------------------------------------------------
`default_nettype none
module tb_ring_election_node;
    timeunit 1ns;
    timeprecision 1ps;
    import ren_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    ring_election_node dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // node model state
    logic [15:0] n_self;
    logic [31:0] n_hb_gap, n_hb_to, n_death_gap, n_relay_to, n_count_gap;
    logic [31:0] n_time, n_hb_rx, n_hb_tx, n_death_t, n_count_t;
    logic [15:0] n_next, n_coord, n_hb_from, n_ring;
    logic        n_head, n_counting;

    item_t pending_items[$];
    msg_t  expected_msgs[$];
    int    errors = 0;
    bit    rx_hold = 0;
    bit    hold_go = 0;
    bit    tx_pause = 0;

    task automatic push_msg(input logic [2:0] k, input logic [15:0] d,
                            input logic [31:0] t, input logic [15:0] a,
                            input logic [15:0] b);
        msg_t m;
        m = '{msg_kind: k, dest_id: d, out_time: t, out_a: a, out_b: b, last: 1'b0};
        expected_msgs.push_back(m);
    endtask

    task automatic predict_node(input item_t it);
        int prev_count;
        logic [15:0] old_next;
        prev_count = expected_msgs.size();
        case (it.operation)
            OP_TICK:
            begin
                n_time = n_time + 1;
                if (n_time - n_hb_tx > n_hb_gap)
                begin
                    n_hb_tx = n_time;
                    push_msg(MK_HEARTBEAT, n_next, n_time, n_self, 16'd0);
                end
                if (n_time - n_hb_rx > n_hb_to && n_time - n_death_t > n_death_gap)
                begin
                    if (n_next != n_hb_from)
                    begin
                        push_msg(MK_DEATH, n_next, n_time, n_hb_from, n_self);
                        n_death_t = n_time;
                    end
                    else
                    begin
                        n_head = 1'b1;
                        n_next = n_self;
                    end
                end
                if (n_self == n_coord && !n_counting && n_time - n_count_t > n_count_gap)
                begin
                    n_count_t = n_time;
                    n_counting = 1'b1;
                    push_msg(MK_COUNT, n_next, n_time, n_self, 16'd0);
                end
            end
            OP_HEARTBEAT:
            begin
                n_hb_rx = it.msg_time;
                n_hb_from = it.sender_id;
            end
            OP_DEATH:
            begin
                if (n_next == it.arg_a)
                begin
                    old_next = n_next;
                    n_next = it.arg_b;
                    if (old_next == n_coord)
                        push_msg(MK_ELECTION, n_next, n_time, n_self, n_self);
                end
                else if (n_self != it.arg_b && n_time - it.msg_time <= n_relay_to)
                    push_msg(MK_DEATH, n_next, it.msg_time, it.arg_a, it.arg_b);
            end
            OP_ELECTION:
            begin
                if (it.arg_a == n_self)
                begin
                    n_counting = 1'b0;
                    n_ring = '0;
                    n_coord = it.arg_b;
                    push_msg(MK_VICTORY, n_next, n_time, n_self, it.arg_b);
                end
                else
                    push_msg(MK_ELECTION, n_next, n_time, it.arg_a,
                             (it.arg_b > n_self) ? it.arg_b : n_self);
            end
            OP_VICTORY:
            begin
                if (it.arg_a != n_self)
                begin
                    n_counting = 1'b0;
                    n_ring = '0;
                    n_coord = it.arg_b;
                    push_msg(MK_VICTORY, n_next, n_time, it.arg_a, it.arg_b);
                end
            end
            OP_COUNT:
            begin
                if (n_self == n_coord)
                begin
                    if (it.arg_a == n_coord)
                    begin
                        n_counting = 1'b0;
                        n_ring = it.arg_b;
                        push_msg(MK_COUNT_END, n_next, n_time, it.arg_a, it.arg_b);
                    end
                end
                else
                    push_msg(MK_COUNT, n_next, n_time, it.arg_a, it.arg_b + 16'd1);
            end
            OP_CHANGE_NEXT: n_next = it.arg_a;
            OP_PING: push_msg(MK_PING_REP, it.sender_id, n_time, n_self, 16'd0);
            OP_START: push_msg(MK_ELECTION, n_next, n_time, n_self, n_self);
            default: ;
        endcase
        if (expected_msgs.size() > prev_count)
            expected_msgs[$].last = 1'b1;
    endtask

    // driver
    int gap_left = 0;
    always @(posedge clk)
    begin
        item_t it;
        if (s_axis_tvalid && s_axis_tready)
        begin
            predict_node(item_t'({s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[47:16],
                                  s_axis_tdata[63:48], s_axis_tdata[79:64]}));
        end
        if (!(s_axis_tvalid && !s_axis_tready))
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_items.size() > 0 && !tx_pause)
            begin
                it = pending_items.pop_front();
                s_axis_tuser <= it.operation;
                s_axis_tdata <= {it.arg_b, it.arg_a, it.msg_time, it.sender_id};
                s_axis_tvalid <= 1'b1;
                gap_left <= ($urandom_range(0, 9) < 6) ? 0 :
                            (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                           : $urandom_range(1, 3));
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        msg_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (expected_msgs.size() == 0)
            begin
                $error("unexpected transfer kind=%0d", m_axis_tuser);
                errors++;
            end
            else
            begin
                want = expected_msgs.pop_front();
                if (m_axis_tuser !== want.msg_kind)
                begin
                    $error("msg_kind exp %0d got %0d", want.msg_kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[15:0] !== want.dest_id)
                begin
                    $error("dest_id exp %0d got %0d", want.dest_id, m_axis_tdata[15:0]);
                    errors++;
                end
                if (m_axis_tdata[47:16] !== want.out_time)
                begin
                    $error("out_time exp %0d got %0d", want.out_time, m_axis_tdata[47:16]);
                    errors++;
                end
                if (m_axis_tdata[63:48] !== want.out_a)
                begin
                    $error("out_a exp %0d got %0d", want.out_a, m_axis_tdata[63:48]);
                    errors++;
                end
                if (m_axis_tdata[79:64] !== want.out_b)
                begin
                    $error("out_b exp %0d got %0d", want.out_b, m_axis_tdata[79:64]);
                    errors++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last exp %0d got %0d", want.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 29) == 0);
    end

    // long receiver hold-off, counted in cycles
    initial
    begin
        int c;
        wait (hold_go);
        @(posedge clk);
        rx_hold = 1;
        for (c = 0; c < 200; c++)
            @(posedge clk);
        rx_hold = 0;
    end

    function automatic logic [15:0] pick_id();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return n_self;
            3: return n_next;
            4: return n_coord;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic item_t rand_item(input int tick_pct);
        item_t it;
        it.operation = ($urandom_range(0, 99) < tick_pct) ? OP_TICK
                       : 4'($urandom_range(0, 15));
        it.sender_id = pick_id();
        case ($urandom_range(0, 3))
            0: it.msg_time = n_time - 32'($urandom_range(0, 50));
            1: it.msg_time = $urandom;
            2: it.msg_time = n_time + 32'($urandom_range(0, 5));
            default: it.msg_time = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        endcase
        it.arg_a = pick_id();
        it.arg_b = pick_id();
        return it;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_SELF_ID:    n_self = val[15:0];
            REG_HB_GAP:     n_hb_gap = val;
            REG_HB_TIMEOUT: n_hb_to = val;
            REG_DEATH_GAP:  n_death_gap = val;
            REG_RELAY_TO:   n_relay_to = val;
            REG_COUNT_GAP:  n_count_gap = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_all();
        wait (pending_items.size() == 0 && !s_axis_tvalid);
        wait (expected_msgs.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic item_t mk(input op_t op, input logic [15:0] s,
                                 input logic [31:0] t, input logic [15:0] a,
                                 input logic [15:0] b);
        item_t it;
        it = '{operation: op, sender_id: s, msg_time: t, arg_a: a, arg_b: b};
        return it;
    endfunction

    initial
    begin
        int ph, i;
        n_self = 16'd1; n_hb_gap = 100; n_hb_to = 500; n_death_gap = 200;
        n_relay_to = 1000; n_count_gap = 1000;
        n_time = '0; n_next = '0; n_coord = '0; n_head = 0; n_hb_from = '0;
        n_hb_rx = '0; n_hb_tx = '0; n_death_t = '0; n_count_t = '0;
        n_counting = 0; n_ring = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: small gaps so every tick branch fires
        write_reg(REG_SELF_ID, 32'd5);
        write_reg(REG_HB_GAP, 32'd0);
        write_reg(REG_HB_TIMEOUT, 32'd0);
        write_reg(REG_DEATH_GAP, 32'd0);
        write_reg(REG_RELAY_TO, 32'd10);
        write_reg(REG_COUNT_GAP, 32'd0);
        pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0));            // two-node ring: head
        pending_items.push_back(mk(OP_CHANGE_NEXT, 0, 0, 16'd9, 0));
        pending_items.push_back(mk(OP_HEARTBEAT, 16'd3, 0, 0, 0));
        pending_items.push_back(mk(OP_START, 0, 0, 0, 0));
        pending_items.push_back(mk(OP_ELECTION, 0, 0, 16'd7, 16'd2));
        pending_items.push_back(mk(OP_ELECTION, 0, 0, 16'd7, 16'hFFFF));
        pending_items.push_back(mk(OP_ELECTION, 0, 0, 16'd5, 16'd5)); // lap done
        pending_items.push_back(mk(OP_TICK, 0, 0, 0, 0));             // three results
        pending_items.push_back(mk(OP_COUNT, 0, 0, 16'd6, 16'd3));    // foreign: dropped
        pending_items.push_back(mk(OP_COUNT, 0, 0, 16'd5, 16'd4));    // count done
        pending_items.push_back(mk(OP_VICTORY, 0, 0, 16'd5, 16'd8));  // own lap: silent
        pending_items.push_back(mk(OP_VICTORY, 0, 0, 16'd2, 16'd8));
        pending_items.push_back(mk(OP_COUNT, 0, 0, 16'd8, 16'hFFFF)); // wrap
        pending_items.push_back(mk(OP_DEATH, 0, 0, 16'd4, 16'd5));    // own notice
        pending_items.push_back(mk(OP_DEATH, 0, 32'hFFFF_FFFF, 16'd4, 16'd2)); // wrapped age: relayed
        pending_items.push_back(mk(OP_DEATH, 0, 1, 16'd4, 16'd2));    // relay
        pending_items.push_back(mk(OP_CHANGE_NEXT, 0, 0, 16'd8, 0));
        pending_items.push_back(mk(OP_DEATH, 0, 0, 16'd8, 16'd0));    // coord died
        pending_items.push_back(mk(OP_PING, 16'hFFFF, 0, 0, 0));
        pending_items.push_back(mk(op_t'(4'd15), 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(mk(op_t'(4'd9), 0, 0, 0, 0));
        drain_all();

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin write_reg(REG_SELF_ID, 32'hFFFF); write_reg(REG_HB_GAP, 32'hFFFF_FFFF);
                         write_reg(REG_HB_TIMEOUT, 32'hFFFF_FFFF);
                         write_reg(REG_DEATH_GAP, 32'hFFFF_FFFF);
                         write_reg(REG_RELAY_TO, 32'hFFFF_FFFF);
                         write_reg(REG_COUNT_GAP, 32'hFFFF_FFFF); end
                1: begin write_reg(REG_SELF_ID, 32'd1); write_reg(REG_HB_GAP, 32'd0);
                         write_reg(REG_HB_TIMEOUT, 32'd0); write_reg(REG_DEATH_GAP, 32'd0);
                         write_reg(REG_RELAY_TO, 32'd0); write_reg(REG_COUNT_GAP, 32'd0); end
                default: begin
                    write_reg(REG_SELF_ID, 32'($urandom_range(1, 65535)));
                    write_reg(REG_HB_GAP, 32'($urandom_range(0, 8)));
                    write_reg(REG_HB_TIMEOUT, 32'($urandom_range(0, 12)));
                    write_reg(REG_DEATH_GAP, 32'($urandom_range(0, 6)));
                    write_reg(REG_RELAY_TO, 32'($urandom_range(0, 40)));
                    write_reg(REG_COUNT_GAP, 32'($urandom_range(0, 10)));
                end
            endcase
            // predictor state is read while the queue is filled, so fill in small batches
            for (i = 0; i < 70; i++)
            begin
                wait (pending_items.size() < 2);
                pending_items.push_back(rand_item(45));
                // hold the receiver off while the sender keeps offering
                if (ph == 2 && i == 5)
                    hold_go = 1;
                // pause the sender until every expected result has come
                if (ph == 3 && i == 35)
                begin
                    tx_pause = 1;
                    wait (!s_axis_tvalid);
                    wait (expected_msgs.size() == 0);
                    tx_pause = 0;
                end
            end
            drain_all();
        end

        wait (expected_msgs.size() == 0);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
